// ===== sv/cuckoo_hash_multi_queue_assert.svh =====
// assertion macros for the cuckoo hash queue block
`ifndef CUCKOO_HASH_MULTI_QUEUE_ASSERT_SVH
`define CUCKOO_HASH_MULTI_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define CHMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHMQ_ASSERT(lbl, prop, msg)
`define CHMQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/chmq_pkg.sv =====
package chmq_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_NOKEY   = 3'd1;
  localparam logic [2:0] STS_INSFAIL = 3'd2;
  localparam logic [2:0] STS_FULL    = 3'd3;
  localparam logic [2:0] STS_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] key;
    logic [15:0] item;
    logic [1:0]  load_way;
    logic        load_bit_value;
    logic [3:0]  load_bit_pos;
    logic [9:0]  load_word;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key_echo;
    logic [15:0] item_out;
    logic [2:0]  status;
    logic [15:0] fail_count;
  } out_word_t;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_HASH  = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_EVAL  = 7'b0010000,
    ST_MOD   = 7'b0100000,
    ST_EVICT = 7'b1000000
  } state_t;

endpackage

// ===== sv/cuckoo_hash_multi_queue.sv =====
// push hit, pop: from accept through hash, bank read and update to a registered result
// insert: each eviction round adds the steps victim select, evict, hash, read, check,
// at most MAX_TRIES rounds; load and unused opcodes answer straight from idle
// one word in flight; next word accepted from the cycle after the result is taken
// reset: synchronous, active low; then a clearing pass over every entry
// of all way banks in parallel, no word accepted until it ends
module cuckoo_hash_multi_queue #(
  parameter int NUM_WAYS    = 4,
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 16,
  parameter int QUEUE_BITS  = 64,
  parameter int ITEM_BITS   = 16,
  parameter int MAX_TRIES   = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  chmq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output chmq_pkg::out_word_t out_data
);

  localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WW  = $clog2(NUM_WAYS);
  localparam int KPW = $clog2(KEY_BITS);
  localparam int KB  = KEY_BITS;
  localparam int IB  = ITEM_BITS;
  localparam int QB  = QUEUE_BITS;
  localparam int EW  = 1 + KB + QB;
  localparam int CAP = QB / IB - 1;
  localparam int TW  = $clog2(MAX_TRIES + 1);
  localparam int MODV = NUM_WAYS - 1;
  localparam int ML   = (MODV > 1) ? $clog2(MODV) : 0;
  localparam int MSH  = IW + ML;
  localparam int PW   = IW + MSH + 1;
  localparam int MREC = ((1 << MSH) + MODV - 1) / MODV;

  chmq_pkg::state_t st_r;

  logic [EW-1:0] ent_mem [NUM_WAYS][TABLE_DEPTH];
  logic [EW-1:0] rd_r    [NUM_WAYS];
  logic [9:0]    hw_r    [NUM_WAYS][2][KEY_BITS];

  logic [IW-1:0] idx_r  [NUM_WAYS];
  logic [IW-1:0] idx_c  [NUM_WAYS];
  logic [IW-1:0] clr_r;
  logic [1:0]    op_r;
  logic [15:0]   key_in_r;
  logic [KB-1:0] cur_key_r;
  logic [QB-1:0] cur_q_r;
  logic [IB-1:0] item_r;
  logic          first_r;
  logic [TW-1:0] try_r;
  logic [WW-1:0] vidx_r;
  logic          tog_r;
  logic [WW-1:0] mod_r;
  logic [15:0]   fail_r;
  logic [15:0]   fail_nxt;
  logic          out_valid_r;
  chmq_pkg::out_word_t out_r;

  logic          we  [NUM_WAYS];
  logic [IW-1:0] wa  [NUM_WAYS];
  logic [EW-1:0] wd  [NUM_WAYS];

  logic [NUM_WAYS-1:0] hit, vld, full;
  logic          any_hit, any_full, any_free, found_ok;
  logic [WW-1:0] found_w, free_w, vp;
  logic [PW-1:0] mod_prod;
  logic [IW-1:0] mod_q, mod_rem;
  logic          fin;
  logic [2:0]    fin_sts;
  logic [IB-1:0] fin_item;

  function automatic logic [QB-1:0] q_push(input logic [QB-1:0] q, input logic [IB-1:0] it);
    logic [QB-1:0] r;
    r = q;
    for (int s = 0; s < CAP; s++) begin
      if (q[IB-1:0] == IB'(s)) r[QB-(s+1)*IB +: IB] = it;
    end
    r[IB-1:0] = q[IB-1:0] + IB'(1);
    return r;
  endfunction

  function automatic logic [QB-1:0] q_pop(input logic [QB-1:0] q);
    logic [QB-1:0] r;
    r = q << IB;
    r[IB-1:0] = q[IB-1:0] - IB'(1);
    return r;
  endfunction

  // tabulation hash of the key in hand
  always_comb begin
    logic [9:0] h;
    for (int w = 0; w < NUM_WAYS; w++) begin
      h = '0;
      for (int k = 0; k < KB; k++) h ^= hw_r[w][cur_key_r[k]][k];
      idx_c[w] = IW'(h) & IW'(TABLE_DEPTH - 1);
    end
  end

  always_comb begin
    any_hit = 1'b0; any_full = 1'b0; any_free = 1'b0; found_ok = 1'b0;
    found_w = '0; free_w = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      vld[w]  = rd_r[w][EW-1];
      hit[w]  = vld[w] && (rd_r[w][QB +: KB] == cur_key_r);
      full[w] = rd_r[w][IB-1:0] >= IB'(CAP);
      if (hit[w]) begin
        any_hit = 1'b1; found_ok = 1'b1; found_w = WW'(w);
        if (full[w]) any_full = 1'b1;
      end
      if (!vld[w]) begin
        any_free = 1'b1; free_w = WW'(w);
      end
    end
    vp = mod_r + WW'(tog_r);
    // index mod (ways - 1) through a reciprocal multiply
    mod_prod = PW'(idx_r[vidx_r]) * PW'(MREC);
    mod_q    = IW'(mod_prod >> MSH);
    mod_rem  = idx_r[vidx_r] - IW'(mod_q * IW'(MODV));
  end

  // bank writes and finish decode
  always_comb begin
    fin = 1'b0; fin_sts = chmq_pkg::STS_OK; fin_item = item_r; fail_nxt = fail_r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      we[w] = 1'b0; wa[w] = idx_r[w]; wd[w] = rd_r[w];
    end
    unique case (st_r)
      chmq_pkg::ST_CLEAR: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          we[w] = 1'b1; wa[w] = clr_r; wd[w] = '0;
        end
      end
      chmq_pkg::ST_EVAL: begin
        if (op_r == chmq_pkg::OP_POP) begin
          fin = 1'b1;
          fin_item = '0;
          if (!found_ok) fin_sts = chmq_pkg::STS_NOKEY;
          else if (rd_r[found_w][IB-1:0] == '0) fin_sts = chmq_pkg::STS_EMPTY;
          else begin
            fin_item = rd_r[found_w][QB-1 -: IB];
            we[found_w] = 1'b1;
            wd[found_w] = {rd_r[found_w][EW-1:QB], q_pop(rd_r[found_w][QB-1:0])};
          end
        end else if (first_r && any_hit) begin
          fin = 1'b1;
          fin_sts = any_full ? chmq_pkg::STS_FULL : chmq_pkg::STS_OK;
          for (int w = 0; w < NUM_WAYS; w++) begin
            if (hit[w] && !full[w]) begin
              we[w] = 1'b1;
              wd[w] = {rd_r[w][EW-1:QB], q_push(rd_r[w][QB-1:0], item_r)};
            end
          end
        end else if (any_free) begin
          fin = 1'b1;
          we[free_w] = 1'b1;
          wd[free_w] = {1'b1, cur_key_r, cur_q_r};
        end
      end
      chmq_pkg::ST_EVICT: begin
        we[vp] = 1'b1;
        wd[vp] = {1'b1, cur_key_r, cur_q_r};
        if (try_r == TW'(MAX_TRIES - 1)) begin
          fin = 1'b1;
          fin_sts = chmq_pkg::STS_INSFAIL;
          fail_nxt = fail_r + 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (we[w]) ent_mem[w][wa[w]] <= wd[w];
      if (st_r == chmq_pkg::ST_READ) rd_r[w] <= ent_mem[w][idx_r[w]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= chmq_pkg::ST_CLEAR;
      clr_r       <= '0;
      tog_r       <= 1'b0;
      fail_r      <= '0;
      out_valid_r <= 1'b0;
      try_r       <= '0;
      vidx_r      <= '0;
      first_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      fail_r <= fail_nxt;
      if (fin) begin
        out_valid_r       <= 1'b1;
        out_r.kind        <= op_r;
        out_r.key_echo    <= key_in_r;
        out_r.item_out    <= 16'(fin_item);
        out_r.status      <= fin_sts;
        out_r.fail_count  <= fail_nxt;
      end
      unique case (st_r)
        chmq_pkg::ST_CLEAR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == IW'(TABLE_DEPTH - 1)) st_r <= chmq_pkg::ST_IDLE;
        end
        chmq_pkg::ST_IDLE: begin
          if (in_valid && in_ready) begin
            op_r      <= in_data.opcode;
            key_in_r  <= in_data.key;
            cur_key_r <= KB'(in_data.key);
            item_r    <= IB'(in_data.item);
            cur_q_r   <= QB'({IB'(in_data.item), {(QB-IB-1){1'b0}}, 1'b1});
            first_r   <= 1'b1;
            try_r     <= '0;
            vidx_r    <= '0;
            if (in_data.opcode == chmq_pkg::OP_PUSH || in_data.opcode == chmq_pkg::OP_POP) begin
              st_r <= chmq_pkg::ST_HASH;
            end else begin
              // load and unused opcodes answer at once
              out_valid_r      <= 1'b1;
              out_r.kind       <= in_data.opcode;
              out_r.key_echo   <= in_data.key;
              out_r.item_out   <= '0;
              out_r.status     <= chmq_pkg::STS_OK;
              out_r.fail_count <= fail_r;
              if (in_data.opcode == chmq_pkg::OP_LOAD && 32'(in_data.load_way) < NUM_WAYS &&
                  32'(in_data.load_bit_pos) < KEY_BITS) begin
                hw_r[WW'(in_data.load_way)][in_data.load_bit_value][KPW'(in_data.load_bit_pos)]
                  <= in_data.load_word;
              end
            end
          end
        end
        chmq_pkg::ST_HASH: begin
          for (int w = 0; w < NUM_WAYS; w++) idx_r[w] <= idx_c[w];
          st_r <= chmq_pkg::ST_READ;
        end
        chmq_pkg::ST_READ: st_r <= chmq_pkg::ST_EVAL;
        chmq_pkg::ST_EVAL: begin
          if (fin) begin
            st_r <= chmq_pkg::ST_IDLE;
            if (op_r == chmq_pkg::OP_PUSH && !(first_r && any_hit)) tog_r <= ~tog_r;
          end else begin
            st_r <= chmq_pkg::ST_MOD;
          end
        end
        chmq_pkg::ST_MOD: begin
          // victim way base: index mod (ways - 1)
          mod_r <= WW'(mod_rem);
          st_r  <= chmq_pkg::ST_EVICT;
        end
        chmq_pkg::ST_EVICT: begin
          tog_r     <= ~tog_r;
          cur_key_r <= rd_r[vp][QB +: KB];
          cur_q_r   <= rd_r[vp][QB-1:0];
          first_r   <= 1'b0;
          try_r     <= try_r + TW'(1);
          vidx_r    <= (vidx_r == WW'(NUM_WAYS - 1)) ? '0 : vidx_r + WW'(1);
          st_r      <= fin ? chmq_pkg::ST_IDLE : chmq_pkg::ST_HASH;
        end
        default: st_r <= chmq_pkg::ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (st_r == chmq_pkg::ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `include "cuckoo_hash_multi_queue_assert.svh"

  `CHMQ_ASSERT(a_no_accept_in_clear, (st_r == chmq_pkg::ST_CLEAR) |-> !in_ready, "accept during clear")
  `CHMQ_ASSERT(a_tries_bound, try_r <= TW'(MAX_TRIES), "eviction rounds over bound")
  `CHMQ_ASSERT(a_fail_counts, (fin && fin_sts == chmq_pkg::STS_INSFAIL) |=> (fail_r == $past(fail_r) + 16'd1), "failure not counted")
  `CHMQ_ASSERT_ALWAYS(a_one_word, in_ready |-> !out_valid_r, "accept with result pending")

endmodule
